[rtl/core/tmre_pkg.sv]
// Shared types and constants of the tile map rectangle engine.
// Holds the command codes, sequencer states and coordinate type.
// No dependencies.
package tmre_pkg;

  localparam int TILE_W = 8;
  localparam int CNT_W  = 13;
  localparam int CRD_W  = 10;

  typedef logic signed [CRD_W-1:0] crd_t;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  typedef enum logic [2:0] {
    MODE_SET       = 3'd0,
    MODE_GET       = 3'd1,
    MODE_FILL_AREA = 3'd2,
    MODE_ROOM      = 3'd3,
    MODE_COUNT     = 3'd4,
    MODE_FILL_ALL  = 3'd5
  } mode_t;

  typedef enum logic [1:0] {
    CFG_MAP_ROWS   = 2'd0,
    CFG_MAP_COLS   = 2'd1,
    CFG_WALL_TILE  = 2'd2,
    CFG_FLOOR_TILE = 2'd3
  } cfg_idx_t;

  localparam logic [6:0]        RST_MAP_ROWS   = 7'd64;
  localparam logic [6:0]        RST_MAP_COLS   = 7'd64;
  localparam logic [TILE_W-1:0] RST_WALL_TILE  = 8'd35;
  localparam logic [TILE_W-1:0] RST_FLOOR_TILE = 8'd46;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PREP,
    ST_ADDR,
    ST_WALK,
    ST_DRAIN,
    ST_DONE
  } state_t;

endpackage

[rtl/core/tmre_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
// Used for the tile store. No dependencies.
module tmre_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/core/tile_map_rect_engine_unit.sv]
// Tile map rectangle engine: a byte tile map with set, get, rectangle fill,
// room drawing, match counting and whole-map fill. Depends on tmre_pkg and tmre_ram.
//
// A command is taken when start is high and busy is low; its single result is
// strobed on out_valid for one cycle and the receiver cannot stall it. The
// sequencer visits one cell per cycle through the single tile RAM: after the
// accepting edge it passes through the PREP and ADDR states, walks the cells and
// strobes its result from DONE (get and count first pass DRAIN to wait for the last
// registered read). Commands that touch no cell go from ADDR straight to DONE.
// After reset the block clears the whole store with busy high; configuration
// writes are taken during that pass.
module tile_map_rect_engine_unit #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [1:0]                          cfg_index,
  input  logic [tmre_pkg::TILE_W-1:0]         cfg_wdata,
  input  logic                                start,
  output logic                                busy,
  input  logic [2:0]                          in_mode,
  input  logic signed [6:0]                   in_row,
  input  logic signed [6:0]                   in_col,
  input  logic [6:0]                          in_area_rows,
  input  logic [6:0]                          in_area_cols,
  input  logic [tmre_pkg::TILE_W-1:0]         in_tile_value,
  output logic                                out_valid,
  output logic [tmre_pkg::TILE_W-1:0]         out_tile_read,
  output logic [tmre_pkg::CNT_W-1:0]          out_match_count,
  output logic                                out_status
);
  import tmre_pkg::*;

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
  localparam crd_t MAX_R = crd_t'(MAX_ROWS);
  localparam crd_t MAX_C = crd_t'(MAX_COLS);
  localparam crd_t ONE   = crd_t'(1);
  localparam crd_t ZERO  = crd_t'(0);

  state_t state_r, state_nxt;

  logic [6:0]        map_rows_r, map_cols_r;
  logic [TILE_W-1:0] wall_tile_r, floor_tile_r;

  mode_t             mode_r;
  crd_t              row_r, col_r, h_r, w_r;
  logic [TILE_W-1:0] val_r;

  crd_t r0_r, c0_r, r_last_r, c_last_r, room_rl_r, room_cl_r;
  logic empty_r, status_r, is_rd_r, is_room_r;

  crd_t          i_r, j_r;
  logic [AW-1:0] addr_r, row_base_r, clr_addr_r;
  logic          rd_vld_r;
  logic [TILE_W-1:0] tile_r;
  logic [CNT_W-1:0]  cnt_r;

  crd_t rows_raw, cols_raw, eff_r, eff_c;
  crd_t row_end, col_end, cr0, cr1, cc0, cc1;
  logic fits, nonzero, inside1, clip_empty;
  crd_t p_r0, p_c0, p_rl, p_cl;
  logic p_empty, p_status, p_rd, p_room;

  logic signed [2*CRD_W-1:0] prod, start_sum;
  logic [AW-1:0] c_aw;
  logic walk_row_end, walk_last, on_border;

  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr;
  logic [TILE_W-1:0] ram_wdata, ram_rdata;

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = (state_r == ST_DONE);
  assign out_status      = status_r;
  assign out_tile_read   = (mode_r == MODE_GET) ? tile_r : '0;
  assign out_match_count = (mode_r == MODE_COUNT) ? cnt_r : '0;

  always_comb begin
    rows_raw = crd_t'(map_rows_r);
    cols_raw = crd_t'(map_cols_r);
    if (rows_raw == ZERO) begin
      eff_r = ONE;
    end else if (rows_raw > MAX_R) begin
      eff_r = MAX_R;
    end else begin
      eff_r = rows_raw;
    end
    if (cols_raw == ZERO) begin
      eff_c = ONE;
    end else if (cols_raw > MAX_C) begin
      eff_c = MAX_C;
    end else begin
      eff_c = cols_raw;
    end
  end

  always_comb begin
    row_end    = row_r + h_r;
    col_end    = col_r + w_r;
    fits       = (row_r >= ZERO) && (col_r >= ZERO) && (row_end <= eff_r) && (col_end <= eff_c);
    nonzero    = (h_r != ZERO) && (w_r != ZERO);
    inside1    = (row_r >= ZERO) && (col_r >= ZERO) && (row_r < eff_r) && (col_r < eff_c);
    cr0        = (row_r < ZERO) ? ZERO : row_r;
    cc0        = (col_r < ZERO) ? ZERO : col_r;
    cr1        = (row_end > eff_r) ? eff_r : row_end;
    cc1        = (col_end > eff_c) ? eff_c : col_end;
    clip_empty = (cr1 <= cr0) || (cc1 <= cc0);
    p_r0     = cr0;
    p_c0     = cc0;
    p_rl     = cr1 - ONE;
    p_cl     = cc1 - ONE;
    p_empty  = 1'b1;
    p_status = 1'b0;
    p_rd     = 1'b0;
    p_room   = 1'b0;
    unique case (mode_r)
      MODE_SET, MODE_GET: begin
        p_r0     = row_r;
        p_c0     = col_r;
        p_rl     = row_r;
        p_cl     = col_r;
        p_empty  = !inside1;
        p_status = !inside1;
        p_rd     = (mode_r == MODE_GET);
      end
      MODE_FILL_AREA: begin
        p_empty  = clip_empty;
        p_status = nonzero && !fits;
      end
      MODE_ROOM: begin
        p_empty  = !(nonzero && fits);
        p_status = !(nonzero && fits);
        p_room   = 1'b1;
      end
      MODE_COUNT: begin
        p_empty = clip_empty;
        p_rd    = 1'b1;
      end
      MODE_FILL_ALL: begin
        p_r0    = ZERO;
        p_c0    = ZERO;
        p_rl    = eff_r - ONE;
        p_cl    = eff_c - ONE;
        p_empty = 1'b0;
      end
      default: begin
        p_status = 1'b1;
      end
    endcase
  end

  always_comb begin
    prod      = (eff_r - r0_r - ONE) * eff_c;
    start_sum = prod + (2*CRD_W)'(c0_r);
    c_aw      = AW'(unsigned'(eff_c));
    walk_row_end = (j_r == c_last_r);
    walk_last    = walk_row_end && (i_r == r_last_r);
    on_border    = (i_r == row_r) || (i_r == room_rl_r) ||
                   (j_r == col_r) || (j_r == room_cl_r);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (clr_addr_r == LAST_ADDR) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_PREP;
        end
      end
      ST_PREP: state_nxt = ST_ADDR;
      ST_ADDR: state_nxt = empty_r ? ST_DONE : ST_WALK;
      ST_WALK: begin
        if (walk_last) begin
          state_nxt = is_rd_r ? ST_DRAIN : ST_DONE;
        end
      end
      ST_DRAIN: state_nxt = ST_DONE;
      ST_DONE:  state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = addr_r;
    ram_wdata = val_r;
    unique case (state_r)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr_r;
        ram_wdata = '0;
      end
      ST_WALK: begin
        ram_we = !is_rd_r;
        ram_re = is_rd_r;
        if (is_room_r) begin
          ram_wdata = on_border ? wall_tile_r : floor_tile_r;
        end
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clr_addr_r   <= '0;
      rd_vld_r     <= 1'b0;
      map_rows_r   <= RST_MAP_ROWS;
      map_cols_r   <= RST_MAP_COLS;
      wall_tile_r  <= RST_WALL_TILE;
      floor_tile_r <= RST_FLOOR_TILE;
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= ram_re;
      if (state_r == ST_CLEAR) begin
        clr_addr_r <= clr_addr_r + AW'(1);
      end
      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_MAP_ROWS:   map_rows_r   <= cfg_wdata[6:0];
          CFG_MAP_COLS:   map_cols_r   <= cfg_wdata[6:0];
          CFG_WALL_TILE:  wall_tile_r  <= cfg_wdata;
          CFG_FLOOR_TILE: floor_tile_r <= cfg_wdata;
          default:        wall_tile_r  <= wall_tile_r;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && start) begin
      mode_r <= mode_t'(in_mode);
      row_r  <= crd_t'(in_row);
      col_r  <= crd_t'(in_col);
      h_r    <= crd_t'(in_area_rows);
      w_r    <= crd_t'(in_area_cols);
      val_r  <= in_tile_value;
    end
    if (state_r == ST_PREP) begin
      r0_r      <= p_r0;
      c0_r      <= p_c0;
      r_last_r  <= p_rl;
      c_last_r  <= p_cl;
      room_rl_r <= row_end - ONE;
      room_cl_r <= col_end - ONE;
      empty_r   <= p_empty;
      status_r  <= p_status;
      is_rd_r   <= p_rd;
      is_room_r <= p_room;
      tile_r    <= '0;
      cnt_r     <= '0;
    end
    if (state_r == ST_ADDR) begin
      addr_r     <= start_sum[AW-1:0];
      row_base_r <= start_sum[AW-1:0];
      i_r        <= r0_r;
      j_r        <= c0_r;
    end
    if (state_r == ST_WALK) begin
      if (walk_row_end) begin
        i_r        <= i_r + ONE;
        j_r        <= c0_r;
        row_base_r <= row_base_r - c_aw;
        addr_r     <= row_base_r - c_aw;
      end else begin
        j_r    <= j_r + ONE;
        addr_r <= addr_r + AW'(1);
      end
    end
    if (rd_vld_r) begin
      tile_r <= ram_rdata;
      if (ram_rdata == val_r && cnt_r != CNT_MAX) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end
    end
  end

  tmre_ram #(
    .WIDTH(TILE_W),
    .DEPTH(DEPTH)
  ) u_tile_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(addr_r),
    .rdata(ram_rdata)
  );

  a_strobe_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid && !busy)
    else $error("result strobe not followed by an idle cycle");

  a_start_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy && !out_valid)
    else $error("accepted transfer did not make the block busy");

  a_count_status_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (mode_r == MODE_COUNT || mode_r == MODE_FILL_ALL) |-> !out_status)
    else $error("count or fill-all reported an error");

  a_no_ram_during_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !busy |-> !ram_we && !ram_re)
    else $error("tile store accessed while idle");

endmodule

[verif/tb_tile_map_rect_engine_unit.sv]
`timescale 1ns / 1ps
// Self-checking testbench for tile_map_rect_engine_unit: a directed command table, then
// random command streams under several map settings, scored against a shadow tile map.
// Depends on tmre_pkg and the engine RTL.
module tb_tile_map_rect_engine_unit;
  import tmre_pkg::*;

  localparam int GRID_ROWS    = 64;
  localparam int GRID_COLS    = 64;
  localparam int QUIET_LIMIT  = 40000;
  localparam int RAND_PER_SET = 16;
  localparam int NUM_SETS     = 7;

  localparam logic [2:0] MODE_RSVD_A = 3'd6;
  localparam logic [2:0] MODE_RSVD_B = 3'd7;
  localparam logic       STAT_OK     = 1'b0;
  localparam logic       STAT_FAIL   = 1'b1;

  typedef struct packed {
    logic [2:0]        mode;
    logic signed [6:0] row;
    logic signed [6:0] col;
    logic [6:0]        area_rows;
    logic [6:0]        area_cols;
    logic [7:0]        tile_value;
  } map_cmd_t;

  typedef struct packed {
    logic [7:0]       tile_read;
    logic [CNT_W-1:0] match_count;
    logic             status;
  } map_res_t;

  typedef struct packed {
    map_cmd_t cmd;
    logic     typed;
    map_res_t want;
  } probe_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [TILE_W-1:0] cfg_wdata;
  logic start;
  logic busy;
  logic [2:0] in_mode;
  logic signed [6:0] in_row;
  logic signed [6:0] in_col;
  logic [6:0] in_area_rows;
  logic [6:0] in_area_cols;
  logic [TILE_W-1:0] in_tile_value;
  logic out_valid;
  logic [TILE_W-1:0] out_tile_read;
  logic [CNT_W-1:0] out_match_count;
  logic out_status;

  logic [7:0] tile_mem [GRID_ROWS*GRID_COLS];
  logic [6:0] rows_cfg  = RST_MAP_ROWS;
  logic [6:0] cols_cfg  = RST_MAP_COLS;
  logic [7:0] wall_cfg  = RST_WALL_TILE;
  logic [7:0] floor_cfg = RST_FLOOR_TILE;

  map_res_t pending_q[$];
  logic     probe_typed = 1'b0;
  map_res_t probe_want  = '0;
  int idle_pct     = 0;
  int err_cnt      = 0;
  int cmd_cnt      = 0;
  int res_cnt      = 0;
  int quiet_cycles = 0;

  tile_map_rect_engine_unit #(
    .MAX_ROWS(GRID_ROWS),
    .MAX_COLS(GRID_COLS)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .start(start),
    .busy(busy),
    .in_mode(in_mode),
    .in_row(in_row),
    .in_col(in_col),
    .in_area_rows(in_area_rows),
    .in_area_cols(in_area_cols),
    .in_tile_value(in_tile_value),
    .out_valid(out_valid),
    .out_tile_read(out_tile_read),
    .out_match_count(out_match_count),
    .out_status(out_status)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    for (int k = 0; k < GRID_ROWS * GRID_COLS; k++) tile_mem[k] = '0;
  end

  function automatic int eff_dim(logic [6:0] v, int top);
    if (v == 0) return 1;
    if (v > top) return top;
    return int'(v);
  endfunction

  function automatic bit on_map(int r, int c, int nr, int nc);
    return r >= 0 && c >= 0 && r < nr && c < nc;
  endfunction

  function automatic int tile_idx(int r, int c, int nr, int nc);
    return (nr - r - 1) * nc + c;
  endfunction

  // Applies one command to the shadow map and returns the result it must produce.
  task automatic run_map_cmd(input map_cmd_t cmd, output map_res_t res);
    int nr, nc, r0, c0, h, w, i, j, lo_r, lo_c, hi_r, hi_c;
    bit missed;
    nr = eff_dim(rows_cfg, GRID_ROWS);
    nc = eff_dim(cols_cfg, GRID_COLS);
    r0 = int'($signed(cmd.row));
    c0 = int'($signed(cmd.col));
    h = int'(cmd.area_rows);
    w = int'(cmd.area_cols);
    missed = 1'b0;
    res = '0;
    case (cmd.mode)
      MODE_SET: begin
        if (on_map(r0, c0, nr, nc)) tile_mem[tile_idx(r0, c0, nr, nc)] = cmd.tile_value;
        else res.status = STAT_FAIL;
      end
      MODE_GET: begin
        if (on_map(r0, c0, nr, nc)) res.tile_read = tile_mem[tile_idx(r0, c0, nr, nc)];
        else res.status = STAT_FAIL;
      end
      MODE_FILL_AREA: begin
        for (i = r0; i < r0 + h; i++) begin
          for (j = c0; j < c0 + w; j++) begin
            if (on_map(i, j, nr, nc)) tile_mem[tile_idx(i, j, nr, nc)] = cmd.tile_value;
            else missed = 1'b1;
          end
        end
        if (missed) res.status = STAT_FAIL;
      end
      MODE_ROOM: begin
        if (h >= 1 && w >= 1 && r0 >= 0 && c0 >= 0 && r0 + h <= nr && c0 + w <= nc) begin
          for (i = r0; i < r0 + h; i++) begin
            tile_mem[tile_idx(i, c0, nr, nc)] = wall_cfg;
            tile_mem[tile_idx(i, c0 + w - 1, nr, nc)] = wall_cfg;
          end
          for (j = c0; j < c0 + w; j++) begin
            tile_mem[tile_idx(r0, j, nr, nc)] = wall_cfg;
            tile_mem[tile_idx(r0 + h - 1, j, nr, nc)] = wall_cfg;
          end
          for (i = r0 + 1; i < r0 + h - 1; i++) begin
            for (j = c0 + 1; j < c0 + w - 1; j++) tile_mem[tile_idx(i, j, nr, nc)] = floor_cfg;
          end
        end else begin
          res.status = STAT_FAIL;
        end
      end
      MODE_COUNT: begin
        lo_r = (r0 < 0) ? 0 : r0;
        lo_c = (c0 < 0) ? 0 : c0;
        hi_r = (r0 + h > nr) ? nr : r0 + h;
        hi_c = (c0 + w > nc) ? nc : c0 + w;
        for (i = lo_r; i < hi_r; i++) begin
          for (j = lo_c; j < hi_c; j++) begin
            if (tile_mem[tile_idx(i, j, nr, nc)] == cmd.tile_value &&
                res.match_count != CNT_MAX)
              res.match_count = res.match_count + CNT_W'(1);
          end
        end
      end
      MODE_FILL_ALL: begin
        for (i = 0; i < nr * nc; i++) tile_mem[i] = cmd.tile_value;
      end
      default: res.status = STAT_FAIL;
    endcase
  endtask

  function automatic probe_row_t mk_probe(logic [2:0] mode, int r, int c, int h, int w,
                                          int v, int typed, int tr, int mc, logic st);
    probe_row_t p;
    p.cmd.mode = mode;
    p.cmd.row = 7'(r);
    p.cmd.col = 7'(c);
    p.cmd.area_rows = 7'(h);
    p.cmd.area_cols = 7'(w);
    p.cmd.tile_value = 8'(v);
    p.typed = (typed != 0);
    p.want.tile_read = 8'(tr);
    p.want.match_count = 13'(mc);
    p.want.status = st;
    return p;
  endfunction

  // Mostly well-formed commands on the current map, with some out-of-range noise.
  function automatic map_cmd_t rand_cmd();
    map_cmd_t c;
    int nr, nc, pick, r0, c0;
    nr = eff_dim(rows_cfg, GRID_ROWS);
    nc = eff_dim(cols_cfg, GRID_COLS);
    pick = $urandom_range(0, 99);
    if (pick < 20) c.mode = MODE_SET;
    else if (pick < 40) c.mode = MODE_GET;
    else if (pick < 56) c.mode = MODE_FILL_AREA;
    else if (pick < 74) c.mode = MODE_ROOM;
    else if (pick < 92) c.mode = MODE_COUNT;
    else if (pick < 96) c.mode = MODE_FILL_ALL;
    else c.mode = $urandom_range(0, 1) ? MODE_RSVD_A : MODE_RSVD_B;
    r0 = $urandom_range(0, nr - 1);
    c0 = $urandom_range(0, nc - 1);
    c.row = 7'(r0);
    c.col = 7'(c0);
    c.area_rows = 7'($urandom_range(0, 6));
    c.area_cols = 7'($urandom_range(0, 6));
    if (c.mode == MODE_ROOM) begin
      c.area_rows = 7'($urandom_range(1, (nr - r0 < 10) ? nr - r0 : 10));
      c.area_cols = 7'($urandom_range(1, (nc - c0 < 10) ? nc - c0 : 10));
    end
    if ($urandom_range(0, 9) == 0) begin
      c.row = 7'($urandom);
      c.col = 7'($urandom);
    end
    if ($urandom_range(0, 11) == 0) begin
      c.area_rows = 7'($urandom_range(0, 64));
      c.area_cols = 7'($urandom_range(0, 64));
    end
    case ($urandom_range(0, 5))
      0: c.tile_value = wall_cfg;
      1: c.tile_value = floor_cfg;
      2: c.tile_value = 8'h00;
      3: c.tile_value = 8'hFF;
      default: c.tile_value = 8'($urandom);
    endcase
    return c;
  endfunction

  // Called and returns at a falling edge; start stays high after the transfer.
  task automatic send_cmd(input map_cmd_t c);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    in_mode <= c.mode;
    in_row <= c.row;
    in_col <= c.col;
    in_area_rows <= c.area_rows;
    in_area_cols <= c.area_cols;
    in_tile_value <= c.tile_value;
    do @(posedge clk); while (busy !== 1'b0);
    @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [TILE_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
  endtask

  task automatic settle();
    while (pending_q.size() != 0 || busy !== 1'b0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  always @(posedge clk) begin : monitor
    map_cmd_t cmd;
    map_res_t want;
    logic took;
    took = 1'b0;
    if (rst_n === 1'b1) begin
      if (cfg_we === 1'b1) begin
        case (cfg_index)
          CFG_MAP_ROWS:   rows_cfg = cfg_wdata[6:0];
          CFG_MAP_COLS:   cols_cfg = cfg_wdata[6:0];
          CFG_WALL_TILE:  wall_cfg = cfg_wdata;
          CFG_FLOOR_TILE: floor_cfg = cfg_wdata;
          default: ;
        endcase
      end
      if (out_valid === 1'b1) begin
        took = 1'b1;
        res_cnt++;
        if (pending_q.size() == 0) begin
          $error("Result transfer arrived with no command outstanding.");
          err_cnt++;
        end else begin
          want = pending_q.pop_front();
          if (out_tile_read !== want.tile_read) begin
            $error("tile_read: expected %0d, got %0d", want.tile_read, out_tile_read);
            err_cnt++;
          end
          if (out_match_count !== want.match_count) begin
            $error("match_count: expected %0d, got %0d", want.match_count, out_match_count);
            err_cnt++;
          end
          if (out_status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_status);
            err_cnt++;
          end
        end
      end
      if (start === 1'b1 && busy === 1'b0) begin
        took = 1'b1;
        cmd.mode = in_mode;
        cmd.row = in_row;
        cmd.col = in_col;
        cmd.area_rows = in_area_rows;
        cmd.area_cols = in_area_cols;
        cmd.tile_value = in_tile_value;
        run_map_cmd(cmd, want);
        if (probe_typed) want = probe_want;
        pending_q.push_back(want);
        cmd_cnt++;
      end
    end
    quiet_cycles = took ? 0 : quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $error("No transfer for %0d cycles.", QUIET_LIMIT);
      $display("[tile_map_rect_engine_unit] ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    probe_row_t probe_tab[$];
    int set_rows [NUM_SETS] = '{1, 64, 0, 5, 100, 0, 16};
    int set_cols [NUM_SETS] = '{1, 64, 100, 12, 0, 0, 16};
    int set_wall [NUM_SETS] = '{0, 255, 35, 7, 128, 0, 200};
    int set_floor[NUM_SETS] = '{255, 0, 46, 1, 127, 0, 99};
    rst_n = 1'b0;
    start = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_MAP_ROWS;
    cfg_wdata = '0;
    in_mode = MODE_SET;
    in_row = '0;
    in_col = '0;
    in_area_rows = '0;
    in_area_cols = '0;
    in_tile_value = '0;

    probe_tab.push_back(mk_probe(MODE_GET, 0, 0, 0, 0, 0, 1, 0, 0, STAT_OK));
    probe_tab.push_back(mk_probe(MODE_GET, 63, 63, 0, 0, 0, 1, 0, 0, STAT_OK));
    probe_tab.push_back(mk_probe(MODE_GET, -64, -64, 0, 0, 0, 1, 0, 0, STAT_FAIL));
    probe_tab.push_back(mk_probe(MODE_SET, 63, 63, 0, 0, 255, 1, 0, 0, STAT_OK));
    probe_tab.push_back(mk_probe(MODE_GET, 63, 63, 0, 0, 0, 1, 255, 0, STAT_OK));
    probe_tab.push_back(mk_probe(MODE_SET, -64, 0, 0, 0, 7, 1, 0, 0, STAT_FAIL));
    probe_tab.push_back(mk_probe(MODE_SET, 0, -1, 0, 0, 7, 1, 0, 0, STAT_FAIL));
    probe_tab.push_back(mk_probe(MODE_FILL_AREA, 60, 60, 8, 8, 8'hAA, 1, 0, 0, STAT_FAIL));
    probe_tab.push_back(mk_probe(MODE_FILL_AREA, 5, 5, 0, 9, 8'h11, 1, 0, 0, STAT_OK));
    probe_tab.push_back(mk_probe(MODE_FILL_AREA, -64, -64, 64, 64, 8'h11, 1, 0, 0, STAT_FAIL));
    probe_tab.push_back(mk_probe(MODE_COUNT, -64, -64, 64, 64, 0, 1, 0, 0, STAT_OK));
    probe_tab.push_back(mk_probe(MODE_COUNT, 56, 56, 8, 8, 8'hAA, 0, 0, 0, STAT_OK));
    probe_tab.push_back(mk_probe(MODE_ROOM, 0, 0, 0, 5, 0, 1, 0, 0, STAT_FAIL));
    probe_tab.push_back(mk_probe(MODE_ROOM, 60, 60, 8, 8, 0, 1, 0, 0, STAT_FAIL));
    probe_tab.push_back(mk_probe(MODE_ROOM, -1, 0, 3, 3, 0, 1, 0, 0, STAT_FAIL));
    probe_tab.push_back(mk_probe(MODE_ROOM, 10, 10, 5, 6, 0, 0, 0, 0, STAT_OK));
    probe_tab.push_back(mk_probe(MODE_ROOM, 20, 20, 1, 1, 0, 0, 0, 0, STAT_OK));
    probe_tab.push_back(mk_probe(MODE_ROOM, 30, 30, 2, 2, 0, 0, 0, 0, STAT_OK));
    probe_tab.push_back(mk_probe(MODE_ROOM, 40, 0, 1, 64, 0, 0, 0, 0, STAT_OK));
    probe_tab.push_back(mk_probe(MODE_GET, 12, 12, 0, 0, 0, 0, 0, 0, STAT_OK));
    probe_tab.push_back(mk_probe(MODE_COUNT, 10, 10, 5, 6, 46, 0, 0, 0, STAT_OK));
    probe_tab.push_back(mk_probe(MODE_FILL_ALL, 0, 0, 0, 0, 8'h5A, 1, 0, 0, STAT_OK));
    probe_tab.push_back(mk_probe(MODE_COUNT, 0, 0, 64, 64, 8'h5A, 1, 0, 4096, STAT_OK));
    probe_tab.push_back(mk_probe(MODE_RSVD_A, 5, 5, 3, 3, 8'h77, 1, 0, 0, STAT_FAIL));
    probe_tab.push_back(mk_probe(MODE_RSVD_B, -1, -1, 64, 64, 8'hFF, 1, 0, 0, STAT_FAIL));
    probe_tab.push_back(mk_probe(MODE_FILL_AREA, 0, 0, 64, 64, 8'h00, 1, 0, 0, STAT_OK));

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    idle_pct = 37;
    foreach (probe_tab[k]) begin
      probe_typed = probe_tab[k].typed;
      probe_want = probe_tab[k].want;
      send_cmd(probe_tab[k].cmd);
    end
    start <= 1'b0;
    probe_typed = 1'b0;
    settle();

    for (int p = 0; p < NUM_SETS; p++) begin
      if (p == 5) begin
        set_rows[p] = $urandom_range(1, 64);
        set_cols[p] = $urandom_range(1, 64);
        set_wall[p] = $urandom_range(0, 255);
        set_floor[p] = $urandom_range(0, 255);
      end
      write_reg(CFG_MAP_ROWS, 8'(set_rows[p]));
      write_reg(CFG_MAP_COLS, 8'(set_cols[p]));
      write_reg(CFG_WALL_TILE, 8'(set_wall[p]));
      write_reg(CFG_FLOOR_TILE, 8'(set_floor[p]));
      cfg_we <= 1'b0;
      idle_pct = (p < 3) ? 37 : (p < 5) ? 57 : 0;
      repeat (RAND_PER_SET) send_cmd(rand_cmd());
      start <= 1'b0;
      settle();
    end

    repeat (16) @(posedge clk);
    $display("Ran %0d commands (%0d from the directed table) over %0d map settings.",
             cmd_cnt, probe_tab.size(), NUM_SETS + 1);
    $display("Checked %0d result transfers; %0d mismatches.", res_cnt, err_cnt);
    if (err_cnt == 0 && pending_q.size() == 0) $display("[tile_map_rect_engine_unit] OK");
    else $display("[tile_map_rect_engine_unit] ERROR");
    $finish;
  end

endmodule
